[hw/rtl/u8d_pkg.sv]
// Shared types and constants for the UTF-8 decoder with newline normalization.
package u8d_pkg;

  typedef enum logic [2:0] {
    PH_BEGIN = 3'd0,
    PH_CONT1 = 3'd1,
    PH_CONT2 = 3'd2,
    PH_CONT3 = 3'd3,
    PH_ERROR = 3'd4
  } phase_t;

  localparam logic [20:0] REPL_CHAR = 21'h00FFFD;
  localparam logic [20:0] BMP_MAX   = 21'h00FFFF;
  localparam logic [20:0] CHAR_CR   = 21'h00000D;
  localparam logic [20:0] CHAR_LF   = 21'h00000A;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

[hw/rtl/u8d_channels.sv]
// Valid/ready channel interfaces for input bytes and output characters.
interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_stream;

  modport source (output valid, output byte_value, output end_of_stream, input ready);
  modport sink   (input valid, input byte_value, input end_of_stream, output ready);
endinterface

interface u8d_char_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        is_replacement;

  modport source (output valid, output code_point, output is_replacement, input ready);
  modport sink   (input valid, input code_point, input is_replacement, output ready);
endinterface

[hw/rtl/utf8_decoder_newline_normalize_top.sv]
// Top level of the UTF-8 decoder with newline normalization.
//
//   channel   dir   payload                            beat when
//   bytes     in    byte_value[7:0], end_of_stream     bytes.valid && bytes.ready
//   chars     out   code_point[20:0], is_replacement   chars.valid && chars.ready
//   cfg       in    cfg_wdata (narrow_chars)           cfg_we
//
// One byte beat per cycle sustained while chars.ready holds; a result passes through the input
// register, then decode logic into the result register.
// Zero or one character per byte beat; end beats flush and clear decode state.
// A stalled result holds the pipe; bytes.ready follows chars.ready through it.
// Reset is synchronous and clears state, valids and narrow_chars.
module utf8_decoder_newline_normalize_top
  import u8d_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  u8d_byte_if.sink      bytes,
  u8d_char_if.source    chars
);

  logic   narrow_chars;
  logic   advance;
  stage_t stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      narrow_chars <= 1'b0;
    end else if (cfg_we) begin
      narrow_chars <= cfg_wdata;
    end
  end

  u8d_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes),
    .advance (advance),
    .stage   (stage)
  );

  u8d_core u_core (
    .clk          (clk),
    .rst          (rst),
    .narrow_chars (narrow_chars),
    .stage        (stage),
    .advance      (advance),
    .chars        (chars)
  );

endmodule

[hw/rtl/u8d_in_stage.sv]
// Input register stage: captures one byte beat ahead of the decode logic.
module u8d_in_stage
  import u8d_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  u8d_byte_if.sink      bytes,
  input  logic          advance,
  output stage_t        stage
);

  logic     valid;
  in_item_t item;

  assign bytes.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (bytes.ready) begin
      valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      item.byte_value    <= bytes.byte_value;
      item.end_of_stream <= bytes.end_of_stream;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

[hw/rtl/u8d_core.sv]
// Decode state, next-state logic, newline folding and result register.
module u8d_core
  import u8d_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          narrow_chars,
  input  stage_t        stage,
  output logic          advance,
  u8d_char_if.source    chars
);

  phase_t      phase, phase_next;
  logic [20:0] acc, acc_next;
  logic        last_was_cr, last_was_cr_next;

  logic        dec_valid;
  logic [20:0] dec_cp;
  logic [20:0] nar_cp;
  logic        nar_repl;

  logic        emit;
  logic [20:0] emit_cp;
  logic        emit_repl;

  logic        res_valid;
  logic [20:0] res_cp;
  logic        res_repl;

  logic [7:0]  b;
  logic        eos;
  logic        is_cont;
  logic        step;

  assign b       = stage.item.byte_value;
  assign eos     = stage.item.end_of_stream;
  assign is_cont = (b[7:6] == 2'b10);
  assign advance = !res_valid || chars.ready;
  assign step    = stage.valid && advance;

  // next state: phase and accumulator
  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    if (eos) begin
      phase_next = PH_BEGIN;
      acc_next   = '0;
    end else begin
      case (phase)
        PH_CONT1: begin
          phase_next = PH_BEGIN;
          acc_next   = '0;
        end
        PH_CONT2: begin
          if (is_cont) begin
            phase_next = PH_CONT1;
            acc_next   = acc | {9'd0, b[5:0], 6'd0};
          end else begin
            phase_next = PH_BEGIN;
            acc_next   = '0;
          end
        end
        PH_CONT3: begin
          if (is_cont) begin
            phase_next = PH_CONT2;
            acc_next   = acc | {3'd0, b[5:0], 12'd0};
          end else begin
            phase_next = PH_BEGIN;
            acc_next   = '0;
          end
        end
        PH_ERROR: begin
          if (!is_cont) begin
            phase_next = PH_BEGIN;
          end
        end
        default: begin
          acc_next = '0;
          if (!b[7]) begin
            phase_next = PH_BEGIN;
          end else if (b[7:5] == 3'b110) begin
            phase_next = PH_CONT1;
            acc_next   = {10'd0, b[4:0], 6'd0};
          end else if (b[7:4] == 4'b1110) begin
            phase_next = PH_CONT2;
            acc_next   = {5'd0, b[3:0], 12'd0};
          end else if (b[7:3] == 5'b11110) begin
            phase_next = PH_CONT3;
            acc_next   = {b[2:0], 18'd0};
          end else begin
            phase_next = PH_ERROR;
          end
        end
      endcase
    end
  end

  // completed character, before narrowing and newline folding
  always_comb begin
    dec_valid = 1'b0;
    dec_cp    = '0;
    if (!eos) begin
      case (phase)
        PH_CONT1: begin
          dec_valid = is_cont;
          dec_cp    = acc | {15'd0, b[5:0]};
        end
        PH_CONT2, PH_CONT3, PH_ERROR: begin
          dec_valid = 1'b0;
        end
        default: begin
          dec_valid = !b[7];
          dec_cp    = {13'd0, b};
        end
      endcase
    end
  end

  assign nar_repl = narrow_chars && (dec_cp > BMP_MAX);
  assign nar_cp   = nar_repl ? REPL_CHAR : dec_cp;

  // outputs and CR tracking
  always_comb begin
    emit             = 1'b0;
    emit_cp          = REPL_CHAR;
    emit_repl        = 1'b1;
    last_was_cr_next = last_was_cr;
    if (eos) begin
      last_was_cr_next = 1'b0;
      case (phase)
        PH_CONT1, PH_CONT2, PH_CONT3, PH_ERROR: emit = 1'b1;
        default:                                emit = 1'b0;
      endcase
    end else if (dec_valid) begin
      if (nar_cp == CHAR_CR) begin
        last_was_cr_next = 1'b1;
        emit             = 1'b1;
        emit_cp          = CHAR_LF;
        emit_repl        = 1'b0;
      end else if (nar_cp == CHAR_LF) begin
        last_was_cr_next = 1'b0;
        emit             = !last_was_cr;
        emit_cp          = CHAR_LF;
        emit_repl        = 1'b0;
      end else begin
        last_was_cr_next = 1'b0;
        emit             = 1'b1;
        emit_cp          = nar_cp;
        emit_repl        = nar_repl;
      end
    end else begin
      // breaking byte: replacement unless a continuation is absorbed
      case (phase)
        PH_CONT1, PH_CONT2, PH_CONT3, PH_ERROR: emit = !is_cont;
        default:                                emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_BEGIN;
      acc         <= '0;
      last_was_cr <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      acc         <= acc_next;
      last_was_cr <= last_was_cr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= stage.valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res_cp   <= emit_cp;
      res_repl <= emit_repl;
    end
  end

  assign chars.valid          = res_valid;
  assign chars.code_point     = res_cp;
  assign chars.is_replacement = res_repl;

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (step && eos) |=> (phase == PH_BEGIN && acc == '0 && !last_was_cr))
    else $error("end beat did not clear decode state");

  a_begin_acc_zero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BEGIN) |-> (acc == '0))
    else $error("accumulator not clear while awaiting lead byte");

  a_repl_value: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_repl) |-> (res_cp == REPL_CHAR))
    else $error("replacement flag on a non-replacement character");

  a_no_cr_out: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_cp != CHAR_CR))
    else $error("CR leaked to output");

  a_narrow_bmp: assert property (@(posedge clk) disable iff (rst)
    (res_valid && narrow_chars) |-> (res_cp <= BMP_MAX))
    else $error("code point above BMP in narrow mode");

endmodule
